// ===== rtl/core/bup_pkg.sv =====
package bup_pkg;

    // Field widths
    localparam int OpWidth     = 2;
    localparam int AdcWidth    = 10;
    localparam int ModeWidth   = 2;
    localparam int TickWidth   = 8;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDatWidth = 10;
    localparam int InDataWidth  = 16;
    localparam int OutDataWidth = 8;

    // Event codes
    localparam logic [OpWidth-1:0] OP_SAMPLE    = 2'd0;
    localparam logic [OpWidth-1:0] OP_TICK      = 2'd1;
    localparam logic [OpWidth-1:0] OP_ON_CHANGE = 2'd2;
    localparam logic [OpWidth-1:0] OP_OFF       = 2'd3;

    // Button modes
    localparam logic [ModeWidth-1:0] MODE_TWO       = 2'd0;
    localparam logic [ModeWidth-1:0] MODE_ALWAYS_ON = 2'd1;
    localparam logic [ModeWidth-1:0] MODE_ON_ONLY   = 2'd2;
    localparam logic [ModeWidth-1:0] MODE_FLIP      = 2'd3;

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] REG_MODE       = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_UPPER      = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_LOWER      = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_LONG_PRESS = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_HOLDOFF    = 3'd4;

    // Reset values
    localparam logic [ModeWidth-1:0] RST_MODE       = MODE_TWO;
    localparam logic [AdcWidth-1:0]  RST_UPPER      = 10'd823;
    localparam logic [AdcWidth-1:0]  RST_LOWER      = 10'd759;
    localparam logic [TickWidth-1:0] RST_LONG_PRESS = 8'd10;
    localparam logic [TickWidth-1:0] RST_HOLDOFF    = 8'd3;

    typedef struct packed {
        logic [ModeWidth-1:0] mode;
        logic [AdcWidth-1:0]  upper_threshold;
        logic [AdcWidth-1:0]  lower_threshold;
        logic [TickWidth-1:0] long_press_ticks;
        logic [TickWidth-1:0] holdoff_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 key;
        logic                 volt;
        logic                 enable;
        logic [TickWidth-1:0] press_count;
        logic [TickWidth-1:0] holdoff;
    } state_t;

    typedef struct packed {
        logic sleep_allowed;
        logic sample_request;
        logic voltage_good;
        logic key_on;
        logic power_enable;
    } result_t;

endpackage

// ===== rtl/core/bup_cfg_regs.sv =====
module bup_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bup_pkg::CfgIdxWidth-1:0]  cfg_addr,
    input  logic [bup_pkg::CfgDatWidth-1:0]  cfg_wdata,
    output bup_pkg::cfg_t                    cfg
);
    import bup_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MODE:       cfg_next.mode             = cfg_wdata[ModeWidth-1:0];
                REG_UPPER:      cfg_next.upper_threshold  = cfg_wdata[AdcWidth-1:0];
                REG_LOWER:      cfg_next.lower_threshold  = cfg_wdata[AdcWidth-1:0];
                REG_LONG_PRESS: cfg_next.long_press_ticks = cfg_wdata[TickWidth-1:0];
                REG_HOLDOFF:    cfg_next.holdoff_ticks    = cfg_wdata[TickWidth-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode             <= RST_MODE;
            cfg_reg.upper_threshold  <= RST_UPPER;
            cfg_reg.lower_threshold  <= RST_LOWER;
            cfg_reg.long_press_ticks <= RST_LONG_PRESS;
            cfg_reg.holdoff_ticks    <= RST_HOLDOFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/bup_step.sv =====
module bup_step (
    input  bup_pkg::cfg_t                  cfg,
    input  bup_pkg::state_t                cur,
    input  logic [bup_pkg::OpWidth-1:0]    operation,
    input  logic [bup_pkg::AdcWidth-1:0]   adc_value,
    input  logic                           on_pressed,
    output bup_pkg::state_t                nxt,
    output bup_pkg::result_t               res
);
    import bup_pkg::*;

    // Enable follows key AND voltage; a falling enable loads the holdoff
    function automatic state_t apply_enable(input state_t s, input logic [TickWidth-1:0] load);
        state_t r;
        r = s;
        if (r.key && r.volt)
        begin
            r.enable = 1'b1;
        end
        else if (r.enable)
        begin
            r.enable  = 1'b0;
            r.holdoff = load;
        end
        return r;
    endfunction

    state_t               st;
    logic                 sample;
    logic                 press_mode;
    logic [TickWidth-1:0] press_inc;

    assign press_mode = (cfg.mode == MODE_TWO) || (cfg.mode == MODE_ON_ONLY);
    assign press_inc  = cur.press_count + 8'd1;

    // Event handling
    always_comb
    begin
        st     = cur;
        sample = 1'b0;
        unique case (operation)
            OP_SAMPLE:
            begin
                if (adc_value > cfg.upper_threshold)
                begin
                    st.volt = 1'b1;
                end
                if (adc_value < cfg.lower_threshold)
                begin
                    st.volt = 1'b0;
                    if (cfg.mode != MODE_ALWAYS_ON)
                    begin
                        st.key = 1'b0;
                    end
                end
                st = apply_enable(st, cfg.holdoff_ticks);
            end
            OP_TICK:
            begin
                sample = 1'b1;
                if (press_mode)
                begin
                    if (on_pressed)
                    begin
                        st.press_count = press_inc;
                        if (press_inc == cfg.long_press_ticks)
                        begin
                            st.press_count = '0;
                            st.key         = 1'b0;
                            st             = apply_enable(st, cfg.holdoff_ticks);
                        end
                    end
                    else
                    begin
                        st.press_count = '0;
                    end
                end
                // holdoff counts down after a possible reload
                if (st.holdoff != '0)
                begin
                    st.holdoff = st.holdoff - 8'd1;
                end
            end
            OP_ON_CHANGE:
            begin
                if (cfg.mode == MODE_FLIP)
                begin
                    if (on_pressed)
                    begin
                        st.key = !cur.key;
                        sample = !cur.key;
                        st     = apply_enable(st, cfg.holdoff_ticks);
                    end
                end
                else if (cfg.mode != MODE_ALWAYS_ON)
                begin
                    if (cur.holdoff == '0)
                    begin
                        st.key = 1'b1;
                        sample = 1'b1;
                        st     = apply_enable(st, cfg.holdoff_ticks);
                    end
                end
            end
            OP_OFF:
            begin
                if (cfg.mode == MODE_TWO)
                begin
                    st.key = 1'b0;
                    st     = apply_enable(st, cfg.holdoff_ticks);
                end
            end
            default:
            begin
                st = cur;
            end
        endcase
    end

    assign nxt = st;

    // Result fields
    assign res.power_enable   = st.enable;
    assign res.key_on         = st.key;
    assign res.voltage_good   = st.volt;
    assign res.sample_request = sample;
    assign res.sleep_allowed  = (cfg.mode != MODE_ALWAYS_ON) && !(st.key && st.volt) &&
                                (st.holdoff == '0);

endmodule

// ===== rtl/core/battery_uvlo_power_switch.sv =====
// Battery power switch with undervoltage lockout.
// Each event is held in the input register, and its result is then registered in the result
// register, which drives the master side.
// Throughput: one event per cycle; s_tready only drops while both the input register and
// the result register are full and the result is stalled.
// Reset (rst_n low, asynchronous): key, voltage-good and enable set, counters cleared,
// configuration registers at their defaults, both stages empty.
module battery_uvlo_power_switch (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] operation, [11:2] adc_value, [12] on_pressed, [15:13] zero
    input  logic [bup_pkg::InDataWidth-1:0]   s_tdata,
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] power_enable, [1] key_on, [2] voltage_good, [3] sample_request,
    // [4] sleep_allowed, [7:5] zero
    output logic [bup_pkg::OutDataWidth-1:0]  m_tdata,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [bup_pkg::CfgIdxWidth-1:0]   cfg_addr,
    input  logic [bup_pkg::CfgDatWidth-1:0]   cfg_wdata
);
    import bup_pkg::*;

    cfg_t                 cfg;
    state_t               state_reg;
    state_t               state_next;
    result_t              res_next;
    result_t              res_reg;
    logic                 in_vld_reg;
    logic [OpWidth-1:0]   in_op_reg;
    logic [AdcWidth-1:0]  in_adc_reg;
    logic                 in_press_reg;
    logic                 out_vld_reg;
    logic                 advance;
    logic                 fire;

    bup_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bup_step u_step (
        .cfg        (cfg),
        .cur        (state_reg),
        .operation  (in_op_reg),
        .adc_value  (in_adc_reg),
        .on_pressed (in_press_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    // Pipeline control
    assign advance  = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg    <= s_tdata[OpWidth-1:0];
            in_adc_reg   <= s_tdata[OpWidth+AdcWidth-1:OpWidth];
            in_press_reg <= s_tdata[OpWidth+AdcWidth];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // Controller state, updated as each event leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.key         <= 1'b1;
            state_reg.volt        <= 1'b1;
            state_reg.enable      <= 1'b1;
            state_reg.press_count <= '0;
            state_reg.holdoff     <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OutDataWidth - $bits(result_t)){1'b0}}, res_reg};

`ifndef SYNTHESIS
    // Enable always tracks key AND voltage
    a_enable_tracks_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.enable == (state_reg.key && state_reg.volt))
        else $error("enable out of step with key and voltage bits");

    // A stalled result means no event is consumed
    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_tready) |=> $stable(state_reg))
        else $error("state changed while result stalled");

    // Sleep is never reported while the output is enabled
    a_sleep_vs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res_reg.sleep_allowed && res_reg.power_enable))
        else $error("sleep allowed with power enabled");

    // An event in the input stage reaches the result stage when it is free
    a_event_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_vld_reg) |=> out_vld_reg)
        else $error("event lost between stages");
`endif

endmodule

// ===== test/battery_uvlo_power_switch_test.sv =====
`timescale 1ns / 100ps

module battery_uvlo_power_switch_test;
    import bup_pkg::*;

    localparam int StallLimit = 2000;
    localparam int DrillLen   = 31;

    // One row of the directed table: a register write or an event
    typedef struct packed {
        bit                     reg_write;
        logic [CfgIdxWidth-1:0] code;      // event code or register index
        logic [CfgDatWidth-1:0] value;     // adc sample or register data
        bit                     pressed;
        bit                     fixed;     // want is typed in below
        result_t                want;      // {sleep, sample, volt, key, enable}
    } drill_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [InDataWidth-1:0]    s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OutDataWidth-1:0]   m_tdata;
    logic                      cfg_wr_en = 1'b0;
    logic [CfgIdxWidth-1:0]    cfg_addr = '0;
    logic [CfgDatWidth-1:0]    cfg_wdata = '0;

    // Shadow copy of the configuration
    logic [ModeWidth-1:0] cfg_mode       = RST_MODE;
    logic [AdcWidth-1:0]  cfg_upper      = RST_UPPER;
    logic [AdcWidth-1:0]  cfg_lower      = RST_LOWER;
    logic [TickWidth-1:0] cfg_long_press = RST_LONG_PRESS;
    logic [TickWidth-1:0] cfg_holdoff    = RST_HOLDOFF;

    // Predicted switch state
    bit                   sw_key     = 1'b1;
    bit                   sw_volt    = 1'b1;
    bit                   sw_enable  = 1'b1;
    logic [TickWidth-1:0] sw_press   = '0;
    logic [TickWidth-1:0] sw_holdoff = '0;

    result_t expected_status[$];
    bit      calm = 1'b0;
    int      errors = 0;
    int      quiet_cycles = 0;
    int      status_checked = 0;
    int      register_writes = 0;
    int      op_seen[4] = '{0, 0, 0, 0};

    string field_names[5] = '{"power_enable", "key_on", "voltage_good",
                              "sample_request", "sleep_allowed"};

    drill_row_t drill[DrillLen] = '{
        // out of reset, default settings
        '{1'b0, OP_TICK,         10'd0,    1'b0, 1'b1, 5'b01111},
        '{1'b0, OP_SAMPLE,       10'd0,    1'b0, 1'b1, 5'b00000},  // lockout trips
        '{1'b0, OP_ON_CHANGE,    10'd0,    1'b1, 1'b1, 5'b00000},  // held off
        '{1'b0, OP_SAMPLE,       10'd1023, 1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_TICK,         10'd0,    1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_TICK,         10'd0,    1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_TICK,         10'd0,    1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_ON_CHANGE,    10'd0,    1'b0, 1'b0, 5'b00000},  // release edge
        '{1'b0, OP_SAMPLE,       10'd759,  1'b0, 1'b0, 5'b00000},  // band edges
        '{1'b0, OP_SAMPLE,       10'd823,  1'b0, 1'b0, 5'b00000},
        '{1'b1, REG_HOLDOFF,     10'd0,    1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_OFF,          10'd0,    1'b0, 1'b0, 5'b00000},
        // on button only, short long-press
        '{1'b1, REG_MODE,        MODE_ON_ONLY, 1'b0, 1'b0, 5'b00000},
        '{1'b1, REG_LONG_PRESS,  10'd2,    1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_ON_CHANGE,    10'd0,    1'b1, 1'b0, 5'b00000},
        '{1'b0, OP_OFF,          10'd0,    1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_TICK,         10'd0,    1'b1, 1'b0, 5'b00000},
        '{1'b0, OP_TICK,         10'd0,    1'b1, 1'b0, 5'b00000},
        // toggle with the longest holdoff
        '{1'b1, REG_HOLDOFF,     10'd255,  1'b0, 1'b0, 5'b00000},
        '{1'b1, REG_MODE,        MODE_FLIP, 1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_ON_CHANGE,    10'd0,    1'b1, 1'b0, 5'b00000},
        '{1'b0, OP_ON_CHANGE,    10'd0,    1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_ON_CHANGE,    10'd0,    1'b1, 1'b0, 5'b00000},
        '{1'b0, OP_TICK,         10'd0,    1'b1, 1'b0, 5'b00000},
        // switchless with overlapping thresholds
        '{1'b1, REG_MODE,        MODE_ALWAYS_ON, 1'b0, 1'b0, 5'b00000},
        '{1'b1, REG_UPPER,       10'd0,    1'b0, 1'b0, 5'b00000},
        '{1'b1, REG_LOWER,       10'd1023, 1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_SAMPLE,       10'd512,  1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_ON_CHANGE,    10'd0,    1'b1, 1'b0, 5'b00000},
        '{1'b0, OP_OFF,          10'd0,    1'b0, 1'b0, 5'b00000},
        '{1'b0, OP_SAMPLE,       10'd0,    1'b0, 1'b0, 5'b00000}
    };

    battery_uvlo_power_switch uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Enable follows key AND voltage; a drop loads the restart holdoff
    function void refresh_enable();
        if (sw_key && sw_volt)
        begin
            sw_enable = 1'b1;
        end
        else if (sw_enable)
        begin
            sw_enable  = 1'b0;
            sw_holdoff = cfg_holdoff;
        end
    endfunction

    // Apply one event to the predicted state and return the status it reports
    function result_t advance_switch(logic [OpWidth-1:0] op, logic [AdcWidth-1:0] adc,
                                     bit pressed);
        result_t st;
        bit      req;
        req = 1'b0;
        case (op)
            OP_SAMPLE:
            begin
                if (adc > cfg_upper)
                    sw_volt = 1'b1;
                if (adc < cfg_lower)
                begin
                    sw_volt = 1'b0;
                    if (cfg_mode != MODE_ALWAYS_ON)
                        sw_key = 1'b0;
                end
                refresh_enable();
            end
            OP_TICK:
            begin
                req = 1'b1;
                if (cfg_mode == MODE_TWO || cfg_mode == MODE_ON_ONLY)
                begin
                    if (pressed)
                    begin
                        sw_press = sw_press + 8'd1;
                        if (sw_press == cfg_long_press)
                        begin
                            sw_press = '0;
                            sw_key   = 1'b0;
                            refresh_enable();
                        end
                    end
                    else
                    begin
                        sw_press = '0;
                    end
                end
                // a holdoff loaded by this tick is already counted down once
                if (sw_holdoff != 0)
                    sw_holdoff = sw_holdoff - 8'd1;
            end
            OP_ON_CHANGE:
            begin
                if (cfg_mode == MODE_FLIP)
                begin
                    if (pressed)
                    begin
                        sw_key = !sw_key;
                        req    = sw_key;
                        refresh_enable();
                    end
                end
                else if (cfg_mode != MODE_ALWAYS_ON && sw_holdoff == 0)
                begin
                    sw_key = 1'b1;
                    req    = 1'b1;
                    refresh_enable();
                end
            end
            OP_OFF:
            begin
                if (cfg_mode == MODE_TWO)
                begin
                    sw_key = 1'b0;
                    refresh_enable();
                end
            end
        endcase
        st.power_enable   = sw_enable;
        st.key_on         = sw_key;
        st.voltage_good   = sw_volt;
        st.sample_request = req;
        st.sleep_allowed  = cfg_mode != MODE_ALWAYS_ON && !(sw_key && sw_volt) &&
                            sw_holdoff == 0;
        return st;
    endfunction

    // Write a register once the block has drained
    task automatic write_register(logic [CfgIdxWidth-1:0] idx, logic [CfgDatWidth-1:0] val);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_MODE:       cfg_mode       = val[ModeWidth-1:0];
            REG_UPPER:      cfg_upper      = val[AdcWidth-1:0];
            REG_LOWER:      cfg_lower      = val[AdcWidth-1:0];
            REG_LONG_PRESS: cfg_long_press = val[TickWidth-1:0];
            REG_HOLDOFF:    cfg_holdoff    = val[TickWidth-1:0];
            default: ;
        endcase
        register_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one event; returns at the edge that accepts it, tvalid left high
    task automatic send_event(logic [OpWidth-1:0] op, logic [AdcWidth-1:0] adc, bit pressed,
                              bit fixed, result_t want);
        result_t predicted;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, pressed, adc, op};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = advance_switch(op, adc, pressed);
        expected_status.push_back(fixed ? want : predicted);
        op_seen[op]++;
    endtask

    // Random events under the current settings
    task automatic run_phase(int count, bit hold_heavy);
        int                  roll;
        int                  near;
        logic [OpWidth-1:0]  op;
        logic [AdcWidth-1:0] adc;
        bit                  pressed;
        bit                  held;
        held = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            // a stretch with no idling on either side
            calm = hold_heavy && i >= 60 && i < 160;
            roll = $urandom_range(99);
            if (hold_heavy)
            begin
                // no release ticks, so the press counter can run all the way round
                op = roll < 95 ? OP_TICK : roll < 97 ? OP_SAMPLE :
                     roll < 99 ? OP_ON_CHANGE : OP_OFF;
                pressed = (op == OP_TICK) ? 1'b1 : 1'($urandom_range(1));
            end
            else
            begin
                op = roll < 30 ? OP_SAMPLE : roll < 65 ? OP_TICK :
                     roll < 90 ? OP_ON_CHANGE : OP_OFF;
                if ($urandom_range(3) == 0)
                    held = !held;
                pressed = (op == OP_TICK) ? held : 1'($urandom_range(1));
            end
            // half the samples land close to a threshold
            if ($urandom_range(1) == 0)
            begin
                adc = 10'($urandom_range(1023));
            end
            else
            begin
                near = int'($urandom_range(1) ? cfg_upper : cfg_lower) +
                       int'($urandom_range(6)) - 3;
                adc = (near < 0) ? 10'd0 : (near > 1023) ? 10'd1023 : 10'(near);
            end
            send_event(op, adc, pressed, 1'b0, '0);
        end
        calm = 1'b0;
    endtask

    // Result sink with random stalls
    always @(negedge clk)
        m_tready <= calm || $urandom_range(99) >= 16;

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        logic [4:0] got;
        logic [4:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[4:0];
            if (expected_status.size() == 0)
            begin
                $error("unexpected result transaction %b", got);
                errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                for (int f = 0; f < 5; f++)
                begin
                    if (got[f] !== want[f])
                    begin
                        $error("%s: expected %0b, got %0b", field_names[f], want[f], got[f]);
                        errors++;
                    end
                end
                status_checked++;
            end
        end
    end

    // Watchdog: no transaction for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= StallLimit)
            begin
                $display("timeout with %0d results outstanding", expected_status.size());
                $display("FAIL battery_uvlo_power_switch");
                $finish;
            end
        end
    end

    initial
    begin
        logic [ModeWidth-1:0]   m;
        logic [CfgDatWidth-1:0] up;
        logic [CfgDatWidth-1:0] lo;
        logic [TickWidth-1:0]   lp;
        logic [TickWidth-1:0]   ho;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DrillLen; i++)
        begin
            if (drill[i].reg_write)
                write_register(drill[i].code, drill[i].value);
            else
                send_event(drill[i].code[OpWidth-1:0], drill[i].value[AdcWidth-1:0],
                           drill[i].pressed, drill[i].fixed, drill[i].want);
        end

        // random phases, one register setting each
        for (int p = 0; p < 8; p++)
        begin
            lo = 10'($urandom_range(900, 100));
            up = lo + 10'($urandom_range(100));
            lp = 8'($urandom_range(12, 2));
            ho = 8'($urandom_range(5));
            case (p)
                0:
                begin
                    m  = MODE_TWO;
                    up = RST_UPPER;
                    lo = RST_LOWER;
                end
                1:
                begin
                    m  = MODE_ON_ONLY;
                    up = 10'd1023;
                    lo = 10'd0;
                    lp = 8'd1;
                    ho = 8'd0;
                end
                2:
                begin
                    m  = MODE_FLIP;
                    lp = 8'd255;
                    ho = 8'd255;
                end
                3:
                begin
                    m  = MODE_ALWAYS_ON;
                    up = 10'd0;
                    lo = 10'd1023;
                end
                4:
                begin
                    // zero long-press count: fires only after the counter wraps
                    m  = MODE_TWO;
                    lp = 8'd0;
                    ho = 8'd2;
                end
                5:       m = MODE_ON_ONLY;
                6:       m = MODE_FLIP;
                default: m = MODE_TWO;
            endcase
            write_register(REG_MODE, 10'(m));
            write_register(REG_UPPER, up);
            write_register(REG_LOWER, lo);
            write_register(REG_LONG_PRESS, 10'(lp));
            write_register(REG_HOLDOFF, 10'(ho));
            run_phase(p == 4 ? 280 : 60, p == 4);
        end

        // drain
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d samples, %0d ticks, %0d on-button and %0d off-button events",
                 op_seen[OP_SAMPLE], op_seen[OP_TICK], op_seen[OP_ON_CHANGE], op_seen[OP_OFF]);
        $display("over %0d register writes in all four modes; %0d results checked",
                 register_writes, status_checked);
        if (errors == 0)
            $display("PASS battery_uvlo_power_switch");
        else
            $display("FAIL battery_uvlo_power_switch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bup_pkg.sv
rtl/core/bup_cfg_regs.sv
rtl/core/bup_step.sv
rtl/core/battery_uvlo_power_switch.sv
test/battery_uvlo_power_switch_test.sv
